### sv/bspl_pkg.sv
`default_nettype none

package bspl_pkg;

    // Default sizing of the node table and of the walk guard.
    localparam int NODE_DEPTH_DEF = 4096;
    localparam int MAX_STEPS_DEF  = 64;

    // Field widths fixed by the interface.
    localparam int COORD_W = 32;
    localparam int CHILD_W = 16;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;
    localparam int SUBSEC_W = 15;

    // Bit of a child word that marks a leaf.
    localparam int LEAF_BIT = 15;

    // Operation codes of an input item.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOCATE = 1'b1;

    // One entry of the node table.
    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] delta_x;
        logic signed [COORD_W-1:0] delta_y;
        logic [CHILD_W-1:0]        front_child;
        logic [CHILD_W-1:0]        back_child;
    } bspl_node_t;

    // Walk sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_MUL_L,
        ST_MUL_R,
        ST_FINISH
    } bspl_state_t;

endpackage

`default_nettype wire

### sv/bspl_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bspl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/bsp_point_locate_top.sv
`default_nettype none

// Channel     Direction  Handshake          Payload
// input item  in         in_valid/in_stall  operation, node_index, line_*, *_child, point_*
// result item out        out_valid/out_stall subsector_index, walk_overrun
// node_count  in         node_count_we      node_count_wdata
//
// A node write gives no result. For each visited node a locate passes through ST_CHECK
// and ST_LOAD; ST_LOAD settles the side when the axis or sign test decides, else ST_MUL_L
// and ST_MUL_R compare the two 16x32 products of the one shared multiplier. A malformed
// walk ends from ST_CHECK; every locate ends in ST_FINISH. Reset clears the sequencer,
// node_count and out_valid, not the node table. A stalled result is held while the next
// item is taken; a finished walk waits.
module bsp_point_locate_top
    import bspl_pkg::*;
#(
    parameter int NODE_DEPTH = NODE_DEPTH_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Configuration
    input  wire logic                       node_count_we,
    input  wire logic [COUNT_W-1:0]         node_count_wdata,
    // Input items
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       operation,
    input  wire logic [INDEX_W-1:0]         node_index,
    input  wire logic signed [COORD_W-1:0]  line_x,
    input  wire logic signed [COORD_W-1:0]  line_y,
    input  wire logic signed [COORD_W-1:0]  line_dx,
    input  wire logic signed [COORD_W-1:0]  line_dy,
    input  wire logic [CHILD_W-1:0]         front_child,
    input  wire logic [CHILD_W-1:0]         back_child,
    input  wire logic signed [COORD_W-1:0]  point_x,
    input  wire logic signed [COORD_W-1:0]  point_y,
    // Result items
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [SUBSEC_W-1:0]             subsector_index,
    output logic                            walk_overrun
);

    localparam int ADDR_W = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int NUM_W  = CHILD_W;
    localparam int HALF_W = COORD_W / 2;
    localparam int PROD_W = HALF_W + COORD_W;

    bspl_state_t state_reg, state_next;

    logic [COUNT_W-1:0]        node_count_reg;
    logic signed [COORD_W-1:0] qx_reg, qx_next;
    logic signed [COORD_W-1:0] qy_reg, qy_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic signed [COORD_W-1:0] ex_reg, ex_next;
    logic signed [COORD_W-1:0] ey_reg, ey_next;
    logic signed [COORD_W-1:0] left_reg, left_next;
    logic [SUBSEC_W-1:0]       res_index_reg, res_index_next;
    logic                      res_overrun_reg, res_overrun_next;

    logic                      out_valid_reg, out_valid_next;
    logic [SUBSEC_W-1:0]       out_index_reg, out_index_next;
    logic                      out_overrun_reg, out_overrun_next;

    logic                      accept;
    logic                      ram_we;
    logic                      ram_re;
    logic [NUM_W-1:0]          waddr_wide;
    bspl_node_t                wr_node;
    bspl_node_t                node;

    // Shared multiplier and the side decision.
    logic signed [HALF_W-1:0]  mul_a;
    logic signed [COORD_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [COORD_W-1:0] prod_hi;
    logic signed [COORD_W-1:0] ex_now;
    logic signed [COORD_W-1:0] ey_now;
    logic                      take;
    logic                      side;
    logic [CHILD_W-1:0]        child;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign waddr_wide = NUM_W'(node_index);
    assign ram_we     = accept && (operation == OP_WRITE)
                        && (32'(node_index) < 32'(NODE_DEPTH));

    always_comb
    begin
        wr_node.origin_x    = line_x;
        wr_node.origin_y    = line_y;
        wr_node.delta_x     = line_dx;
        wr_node.delta_y     = line_dy;
        wr_node.front_child = front_child;
        wr_node.back_child  = back_child;
    end

    bspl_ram #(
        .WIDTH ($bits(bspl_node_t)),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_wide[ADDR_W-1:0]),
        .wdata (wr_node),
        .re    (ram_re),
        .raddr (num_reg[ADDR_W-1:0]),
        .rdata (node)
    );

    // The multiplier forms (dy >> 16) * ex first, then ey * (dx >> 16).
    assign mul_a   = (state_reg == ST_MUL_L) ? node.delta_y[COORD_W-1:HALF_W]
                                             : node.delta_x[COORD_W-1:HALF_W];
    assign mul_b   = (state_reg == ST_MUL_L) ? ex_reg : ey_reg;
    assign prod    = mul_a * mul_b;
    assign prod_hi = prod[PROD_W-1:HALF_W];

    assign ex_now  = qx_reg - node.origin_x;
    assign ey_now  = qy_reg - node.origin_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            node_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (node_count_we)
            begin
                node_count_reg <= node_count_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg          <= qx_next;
        qy_reg          <= qy_next;
        num_reg         <= num_next;
        step_reg        <= step_next;
        ex_reg          <= ex_next;
        ey_reg          <= ey_next;
        left_reg        <= left_next;
        res_index_reg   <= res_index_next;
        res_overrun_reg <= res_overrun_next;
        out_index_reg   <= out_index_next;
        out_overrun_reg <= out_overrun_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        qx_next          = qx_reg;
        qy_next          = qy_reg;
        num_next         = num_reg;
        step_next        = step_reg;
        ex_next          = ex_reg;
        ey_next          = ey_reg;
        left_next        = left_reg;
        res_index_next   = res_index_reg;
        res_overrun_next = res_overrun_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_index_next   = out_index_reg;
        out_overrun_next = out_overrun_reg;
        ram_re           = 1'b0;
        take             = 1'b0;
        side             = 1'b0;
        child            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_LOCATE))
                begin
                    qx_next          = point_x;
                    qy_next          = point_y;
                    num_next         = NUM_W'(node_count_reg) - NUM_W'(1);
                    step_next        = '0;
                    res_index_next   = '0;
                    res_overrun_next = 1'b0;
                    // An empty tree answers subsector zero at once.
                    state_next = (node_count_reg == '0) ? ST_FINISH : ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                // The walk guard and a node number past the table both
                // end the walk as malformed.
                if ((step_reg == STEP_W'(MAX_STEPS))
                    || (32'(num_reg) >= 32'(NODE_DEPTH)))
                begin
                    res_overrun_next = 1'b1;
                    state_next       = ST_FINISH;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                ex_next = ex_now;
                ey_next = ey_now;
                if (node.delta_x == '0)
                begin
                    take = 1'b1;
                    side = (qx_reg <= node.origin_x) ? (node.delta_y > 0)
                                                     : (node.delta_y < 0);
                end
                else if (node.delta_y == '0)
                begin
                    take = 1'b1;
                    side = (qy_reg <= node.origin_y) ? (node.delta_x < 0)
                                                     : (node.delta_x > 0);
                end
                else if ((node.delta_y[COORD_W-1] ^ node.delta_x[COORD_W-1]
                          ^ ex_now[COORD_W-1] ^ ey_now[COORD_W-1]) == 1'b1)
                begin
                    // Opposite signs settle the side without a product.
                    take = 1'b1;
                    side = node.delta_y[COORD_W-1] ^ ex_now[COORD_W-1];
                end
                else
                begin
                    state_next = ST_MUL_L;
                end
            end

            ST_MUL_L:
            begin
                left_next  = prod_hi;
                state_next = ST_MUL_R;
            end

            ST_MUL_R:
            begin
                take = 1'b1;
                side = !(prod_hi < left_reg);
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_index_next   = res_index_reg;
                    out_overrun_next = res_overrun_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Follow the chosen child: a leaf ends the walk, otherwise visit it.
        if (take)
        begin
            child = side ? node.back_child : node.front_child;
            if (child[LEAF_BIT])
            begin
                res_index_next = child[SUBSEC_W-1:0];
                state_next     = ST_FINISH;
            end
            else
            begin
                num_next   = child;
                step_next  = step_reg + STEP_W'(1);
                state_next = ST_CHECK;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign subsector_index = out_index_reg;
    assign walk_overrun    = out_overrun_reg;

endmodule

`default_nettype wire

### tb/tb_bsp_point_locate_top.sv
module tb_bsp_point_locate_top;
    import bspl_pkg::*;

    // Random items that follow the directed table.
    localparam int RANDOM_ITEMS = 1730;
    // Cycles the block may still need for a node write after the last result.
    localparam int SETTLE_CYCLES = 8;

    // One input item as the sender drives it. Fields that the operation does
    // not use are filled with random bits too.
    typedef struct packed {
        logic                      op;
        logic [INDEX_W-1:0]        idx;
        logic signed [COORD_W-1:0] lx, ly, ldx, ldy;
        logic [CHILD_W-1:0]        fc, bc;
        logic signed [COORD_W-1:0] px, py;
    } bsp_request_t;

    // The answer to one locate item.
    typedef struct packed {
        logic [SUBSEC_W-1:0] sub;
        logic                ovr;
    } leaf_answer_t;

    // A row of the directed table is either a node_count write or an item.
    typedef enum logic {ROW_COUNT, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [COUNT_W-1:0]  count;
        bsp_request_t        rq;
        logic                typed;
        logic [SUBSEC_W-1:0] want_sub;
        logic                want_ovr;
    } dir_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      node_count_we;
    logic [COUNT_W-1:0]        node_count_wdata;
    logic                      in_valid;
    logic                      in_stall;
    logic                      operation;
    logic [INDEX_W-1:0]        node_index;
    logic signed [COORD_W-1:0] line_x;
    logic signed [COORD_W-1:0] line_y;
    logic signed [COORD_W-1:0] line_dx;
    logic signed [COORD_W-1:0] line_dy;
    logic [CHILD_W-1:0]        front_child;
    logic [CHILD_W-1:0]        back_child;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      out_valid;
    logic                      out_stall;
    logic [SUBSEC_W-1:0]       subsector_index;
    logic                      walk_overrun;

    // Our own copy of the node table and of node_count. The flags record which
    // entries hold data, so that the stimulus never walks into an entry that
    // was never loaded; the list holds the same indexes for quick picking.
    bspl_node_t         node_model [NODE_DEPTH_DEF];
    bit                 written_node [NODE_DEPTH_DEF];
    int                 written_list [$];
    logic [COUNT_W-1:0] count_model;

    // Answers of accepted locate items, oldest first.
    leaf_answer_t pending_locates [$];

    dir_row_t dir_rows [$];

    // Idling control: one burst starts with odds 1 in idle_odds per cycle,
    // zero means no idling at all, and calm switches idling off for the tail.
    int idle_odds;
    bit calm;
    int stall_left;

    int mismatches;
    int locates_sent;
    int writes_sent;
    int overruns_seen;
    int count_writes;

    bsp_point_locate_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .node_count_we    (node_count_we),
        .node_count_wdata (node_count_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .node_index       (node_index),
        .line_x           (line_x),
        .line_y           (line_y),
        .line_dx          (line_dx),
        .line_dy          (line_dy),
        .front_child      (front_child),
        .back_child       (back_child),
        .point_x          (point_x),
        .point_y          (point_y),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .subsector_index  (subsector_index),
        .walk_overrun     (walk_overrun)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // A hung handshake or a walk that never ends lands here. The bound is
    // several times the slowest correct run, where every locate runs into the
    // walk guard and every item meets the longest gap and stall.
    initial
    begin
        #40000000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %0d at %0t: %s, got %0d, want %0d",
                 mismatches, $realtime, what, got, want);
    endtask

    // Side of the partition line on which the point lies: 0 is the front
    // child, 1 the back child.
    function automatic logic side_of(bspl_node_t nd, logic signed [31:0] qx,
                                     logic signed [31:0] qy);
        logic signed [31:0] ox, oy, ldx, ldy, ex, ey, signs;
        logic signed [63:0] ex_w, ey_w, dx_hi, dy_hi, left_p, right_p;
        ox  = nd.origin_x;
        oy  = nd.origin_y;
        ldx = nd.delta_x;
        ldy = nd.delta_y;
        // Vertical and horizontal lines only need a compare on one axis.
        if (ldx == 0)
        begin
            if (qx <= ox)
                return ldy > 0;
            return ldy < 0;
        end
        if (ldy == 0)
        begin
            if (qy <= oy)
                return ldx < 0;
            return ldx > 0;
        end
        ex = qx - ox;
        ey = qy - oy;
        // When the signs alone settle the cross product, skip the multiply.
        signs = ldy ^ ldx ^ ex ^ ey;
        if (signs[31])
            return ldy[31] ^ ex[31];
        ex_w    = ex;
        ey_w    = ey;
        dx_hi   = ldx >>> 16;
        dy_hi   = ldy >>> 16;
        left_p  = (dy_hi * ex_w) >>> 16;
        right_p = (ey_w * dx_hi) >>> 16;
        return !(right_p < left_p);
    endfunction

    // Walk the tree from the root and return the leaf the point falls in.
    function automatic leaf_answer_t locate_leaf(logic signed [31:0] qx,
                                                 logic signed [31:0] qy);
        leaf_answer_t ans;
        int num;
        logic [CHILD_W-1:0] child;
        ans = '0;
        if (count_model == 0)
            return ans;
        num = count_model - 1;
        for (int s = 0; s < MAX_STEPS_DEF; s++)
        begin
            // A node number past the table ends the walk as malformed.
            if (num >= NODE_DEPTH_DEF)
            begin
                ans.ovr = 1'b1;
                return ans;
            end
            child = side_of(node_model[num], qx, qy) ? node_model[num].back_child
                                                      : node_model[num].front_child;
            if (child[LEAF_BIT])
            begin
                ans.sub = child[SUBSEC_W-1:0];
                return ans;
            end
            num = child;
        end
        // The step limit ran out without a leaf.
        ans.ovr = 1'b1;
        return ans;
    endfunction

    // Bring our copy up to date with an item the block has just taken and
    // queue the answer a locate must produce.
    function automatic void take_item(bsp_request_t rq, logic typed,
                                      logic [SUBSEC_W-1:0] want_sub, logic want_ovr);
        leaf_answer_t ans;
        if (rq.op == OP_WRITE)
        begin
            node_model[rq.idx].origin_x    = rq.lx;
            node_model[rq.idx].origin_y    = rq.ly;
            node_model[rq.idx].delta_x     = rq.ldx;
            node_model[rq.idx].delta_y     = rq.ldy;
            node_model[rq.idx].front_child = rq.fc;
            node_model[rq.idx].back_child  = rq.bc;
            if (!written_node[rq.idx])
            begin
                written_node[rq.idx] = 1'b1;
                written_list.push_back(rq.idx);
            end
            writes_sent++;
        end
        else
        begin
            ans = locate_leaf(rq.px, rq.py);
            if (typed)
            begin
                ans.sub = want_sub;
                ans.ovr = want_ovr;
            end
            pending_locates.push_back(ans);
            locates_sent++;
        end
    endfunction

    function automatic bsp_request_t random_fill();
        bsp_request_t rq;
        rq.op  = 1'($urandom);
        rq.idx = INDEX_W'($urandom);
        rq.lx  = $urandom;
        rq.ly  = $urandom;
        rq.ldx = $urandom;
        rq.ldy = $urandom;
        rq.fc  = CHILD_W'($urandom);
        rq.bc  = CHILD_W'($urandom);
        rq.px  = $urandom;
        rq.py  = $urandom;
        return rq;
    endfunction

    // A signed offset whose magnitude spans every scale from full range down.
    function automatic logic signed [31:0] rand_offset();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 30);
    endfunction

    // A child word for node idx. Non-leaf children only ever name loaded
    // entries, the node itself, or numbers past the table, so a walk never
    // reads an entry that holds no data. Within a tree the children mostly
    // point a few entries back, which gives deep walks.
    function automatic logic [CHILD_W-1:0] pick_child(int idx, int base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 || (r < 88 && idx <= base))
            return {1'b1, 15'($urandom)};
        if (r < 88)
            return CHILD_W'($urandom_range((idx > base + 6) ? idx - 6 : base, idx - 1));
        if (r < 94)
            return CHILD_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
        if (r < 96)
            return CHILD_W'(idx);
        return CHILD_W'($urandom_range(NODE_DEPTH_DEF, 32767));
    endfunction

    function automatic bsp_request_t make_node(int idx, int base,
                                               logic signed [31:0] cx,
                                               logic signed [31:0] cy);
        bsp_request_t rq;
        rq     = random_fill();
        rq.op  = OP_WRITE;
        rq.idx = INDEX_W'(idx);
        // Most lines cluster around the tree's center so that points land on
        // both sides at every level.
        if ($urandom_range(0, 4) != 0)
        begin
            rq.lx = cx + rand_offset();
            rq.ly = cy + rand_offset();
        end
        case ($urandom_range(0, 11))
            0:
            begin
                rq.ldx = '0;
                rq.ldy = '0;
            end
            1, 2: rq.ldx = '0;
            3, 4: rq.ldy = '0;
            default:
            begin
                rq.ldx = rand_offset();
                rq.ldy = rand_offset();
            end
        endcase
        rq.fc = pick_child(idx, base);
        rq.bc = pick_child(idx, base);
        return rq;
    endfunction

    function automatic bsp_request_t make_locate(int root, logic signed [31:0] cx,
                                                 logic signed [31:0] cy);
        bsp_request_t rq;
        rq    = random_fill();
        rq.op = OP_LOCATE;
        case ($urandom_range(0, 19))
            0, 1, 2: ;
            // Points exactly on the root's axis exercise the "less or equal".
            3, 4:
            begin
                rq.px = node_model[root].origin_x;
                rq.py = cy + rand_offset();
            end
            5:
            begin
                rq.px = cx + rand_offset();
                rq.py = node_model[root].origin_y;
            end
            default:
            begin
                rq.px = cx + rand_offset();
                rq.py = cy + rand_offset();
            end
        endcase
        return rq;
    endfunction

    function automatic void add_count(int v);
        dir_row_t row;
        row       = '0;
        row.kind  = ROW_COUNT;
        row.count = COUNT_W'(v);
        dir_rows.push_back(row);
    endfunction

    function automatic void add_node(int idx, logic signed [31:0] x, y, dx, dy,
                                     logic [CHILD_W-1:0] fc, bc);
        dir_row_t row;
        row        = '0;
        row.kind   = ROW_ITEM;
        row.rq     = random_fill();
        row.rq.op  = OP_WRITE;
        row.rq.idx = INDEX_W'(idx);
        row.rq.lx  = x;
        row.rq.ly  = y;
        row.rq.ldx = dx;
        row.rq.ldy = dy;
        row.rq.fc  = fc;
        row.rq.bc  = bc;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_locate(logic signed [31:0] px, py, logic typed,
                                       logic [SUBSEC_W-1:0] want_sub, logic want_ovr);
        dir_row_t row;
        row          = '0;
        row.kind     = ROW_ITEM;
        row.rq       = random_fill();
        row.rq.op    = OP_LOCATE;
        row.rq.px    = px;
        row.rq.py    = py;
        row.typed    = typed;
        row.want_sub = want_sub;
        row.want_ovr = want_ovr;
        dir_rows.push_back(row);
    endfunction

    // Offer one item, hold it until the block takes it, then maybe leave a
    // random gap before the next one.
    task automatic send(bsp_request_t rq, logic typed, logic [SUBSEC_W-1:0] want_sub,
                        logic want_ovr);
        operation   <= rq.op;
        node_index  <= rq.idx;
        line_x      <= rq.lx;
        line_y      <= rq.ly;
        line_dx     <= rq.ldx;
        line_dy     <= rq.ldy;
        front_child <= rq.fc;
        back_child  <= rq.bc;
        point_x     <= rq.px;
        point_y     <= rq.py;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        take_item(rq, typed, want_sub, want_ovr);
        if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11))
                @(posedge clk);
        end
    endtask

    // Stop sending and wait until every answer is in and a node write that
    // may still be in flight has landed.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_locates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // node_count is only written while the block is idle.
    task automatic set_count(int v);
        settle();
        node_count_we    <= 1'b1;
        node_count_wdata <= COUNT_W'(v);
        @(posedge clk);
        node_count_we <= 1'b0;
        count_model = COUNT_W'(v);
        count_writes++;
    endtask

    // Random phases: each builds a fresh tree in a random stretch of the
    // table, roots node_count at it, and then mixes locates with rewrites of
    // tree nodes and stray writes elsewhere. A few phases use an empty or an
    // oversized tree instead.
    task automatic run_random_phases();
        int made;
        int n;
        int base;
        int m;
        int pick;
        int j;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        bsp_request_t rq;
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0: idle_odds = 0;
                1: idle_odds = 8;
                default: idle_odds = 3;
            endcase
            n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                              : $urandom_range(25, 100);
            base = $urandom_range(0, NODE_DEPTH_DEF - n);
            cx = ($urandom_range(0, 3) == 0) ? $urandom : rand_offset();
            cy = ($urandom_range(0, 3) == 0) ? $urandom : rand_offset();
            for (int i = base; i < base + n; i++)
            begin
                send(make_node(i, base, cx, cy), 1'b0, '0, 1'b0);
                made++;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                set_count(0);
            else if (pick < 6)
                set_count($urandom_range(NODE_DEPTH_DEF + 1, 8191));
            else
                set_count(base + n);
            m = $urandom_range(10, 40);
            for (int k = 0; k < m; k++)
            begin
                pick = $urandom_range(0, 99);
                // Now and then the sender holds back until all answers are in.
                if (pick < 3)
                    settle();
                if (pick < 8)
                    rq = make_node(base + $urandom_range(0, n - 1), base, cx, cy);
                else if (pick < 12)
                begin
                    j  = $urandom_range(0, NODE_DEPTH_DEF - 1);
                    rq = make_node(j, j, cx, cy);
                end
                else
                    rq = make_locate(base + n - 1, cx, cy);
                send(rq, 1'b0, '0, 1'b0);
                made++;
                calm = (made > RANDOM_ITEMS * 17 / 20);
            end
        end
    endtask

    // Result side: check every taken result against the oldest answer and
    // throw in random stall bursts.
    always @(posedge clk)
    begin
        leaf_answer_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_locates.size() == 0)
                    report_mismatch("result with no locate waiting", subsector_index, 0);
                else
                begin
                    want = pending_locates.pop_front();
                    if (subsector_index !== want.sub)
                        report_mismatch("subsector_index", subsector_index, want.sub);
                    if (walk_overrun !== want.ovr)
                        report_mismatch("walk_overrun", walk_overrun, want.ovr);
                    if (walk_overrun === 1'b1)
                        overruns_seen++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int w;
        rst_n            <= 1'b0;
        node_count_we    <= 1'b0;
        node_count_wdata <= '0;
        in_valid         <= 1'b0;
        operation        <= OP_WRITE;
        node_index       <= '0;
        line_x           <= '0;
        line_y           <= '0;
        line_dx          <= '0;
        line_dy          <= '0;
        front_child      <= '0;
        back_child       <= '0;
        point_x          <= '0;
        point_y          <= '0;
        count_model   = '0;
        calm          = 1'b0;
        idle_odds     = 4;
        mismatches    = 0;
        locates_sent  = 0;
        writes_sent   = 0;
        overruns_seen = 0;
        count_writes  = 0;

        // Directed table. Answers are typed in only for the empty tree and the
        // malformed-walk cases; every other locate goes through locate_leaf.
        // With no nodes at all a locate answers zero.
        add_locate(32'sh80000000, 32'sh7FFFFFFF, 1'b1, '0, 1'b0);
        // A vertical line through x = 0; points on the line and right of it.
        add_node(0, 0, 0, 0, 32'sh00010000, 16'h8001, 16'h8002);
        add_count(1);
        add_locate(0, 32'sh12345678, 1'b0, '0, 1'b0);
        add_locate(1, -7, 1'b0, '0, 1'b0);
        // A horizontal line pointing left, with the largest subsector on its
        // front and node 0 behind it.
        add_node(1, 0, 0, -32'sh00010000, 0, 16'hFFFF, 16'h0000);
        add_count(2);
        add_locate(-3, 0, 1'b0, '0, 1'b0);
        add_locate(-3, 5, 1'b0, '0, 1'b0);
        // A sloped line at the coordinate extremes. Its back child is a node
        // number past the table. The first point needs the product compare,
        // the second is settled by the sign test.
        add_node(2, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                 16'h0001, 16'h7FFF);
        add_count(3);
        add_locate(0, 32'sh7FFFFFFF, 1'b0, '0, 1'b0);
        add_locate(0, 0, 1'b0, '0, 1'b0);
        add_locate(32'sh7FFFFFFF, 32'sh80000000, 1'b0, '0, 1'b0);
        // A node whose children are itself trips the walk guard.
        add_node(3, 32'sh00100000, -32'sh00100000, 32'sh00030000, -32'sh00050000,
                 16'h0003, 16'h0003);
        add_count(4);
        add_locate(5, 5, 1'b1, '0, 1'b1);
        // A root past the table is malformed from the first step.
        add_count(8191);
        add_locate(0, 0, 1'b1, '0, 1'b1);
        add_count(NODE_DEPTH_DEF + 1);
        add_locate(-1, -1, 1'b1, '0, 1'b1);
        // The last table entry as root of a full-size tree.
        add_node(NODE_DEPTH_DEF - 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0,
                 16'h8000, 16'h0000);
        add_count(NODE_DEPTH_DEF);
        add_locate(32'sh7FFFFFFF, 0, 1'b0, '0, 1'b0);
        add_locate(32'sh80000000, 32'sh80000000, 1'b0, '0, 1'b0);
        add_count(3);
        add_locate(32'sh80000000, 32'sh80000000, 1'b0, '0, 1'b0);

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_COUNT)
                set_count(dir_rows[r].count);
            else
                send(dir_rows[r].rq, dir_rows[r].typed, dir_rows[r].want_sub,
                     dir_rows[r].want_ovr);
        end

        run_random_phases();

        // Drain: every locate must have answered within a bounded time.
        calm = 1'b1;
        in_valid <= 1'b0;
        for (w = 0; w < 5000 && pending_locates.size() != 0; w++)
            @(posedge clk);
        if (pending_locates.size() != 0)
            report_mismatch("locates left without a result", pending_locates.size(), 0);
        repeat (300)
            @(posedge clk);

        $display("covered %0d locates and %0d node writes over %0d node_count settings",
                 locates_sent, writes_sent, count_writes);
        $display("walks that ended malformed: %0d, mismatches: %0d",
                 overruns_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
